// File: design/page_heap_record_allocator_assert.svh
// Assertion macros for the page heap record allocator.
`ifndef PAGE_HEAP_RECORD_ALLOCATOR_ASSERT_SVH
`define PAGE_HEAP_RECORD_ALLOCATOR_ASSERT_SVH

// Checks that a condition implies a consequence on the same edge.
`define PHRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define PHRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/phra_pkg.sv
`default_nettype none
package phra_pkg;

    localparam int RECORDS    = 256;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_BITS  = 48;
    localparam int IDX_W      = $clog2(RECORDS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LEN_W      = $clog2(PAGE_BYTES) + 1;
    localparam int SIZE_W     = 16;
    localparam int SPLIT_W    = 13;
    localparam int REC_W      = 2 * ADDR_BITS + LEN_W + 1;

    localparam logic [2:0] ST_REUSED    = 3'd0;
    localparam logic [2:0] ST_BUMPED    = 3'd1;
    localparam logic [2:0] ST_BAD       = 3'd2;
    localparam logic [2:0] ST_NO_RECORD = 3'd3;
    localparam logic [2:0] ST_NO_PAGE   = 3'd4;
    localparam logic [2:0] ST_FREED     = 3'd5;
    localparam logic [2:0] ST_RELEASED  = 3'd6;
    localparam logic [2:0] ST_NOT_FOUND = 3'd7;

    typedef struct packed {
        logic [ADDR_BITS-1:0] page;
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     len;
        logic                 live;
    } rec_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FIT_RD,
        S_FIT_CHK,
        S_NU_RD,
        S_NU_CHK,
        S_SPLIT_WR,
        S_BUMP,
        S_FREE_RD,
        S_FREE_CHK,
        S_LIVE_RD,
        S_LIVE_CHK,
        S_DROP_RD,
        S_DROP_CHK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        NU_SPLIT,
        NU_BUMP
    } nu_goal_t;

endpackage
`default_nettype wire

// File: design/phra_ram.sv
`default_nettype none
module phra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/phra_ctrl.sv
`default_nettype none
module phra_ctrl (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 cmd,
    input  wire logic [phra_pkg::SIZE_W-1:0]          size,
    input  wire logic [15:0]                          alignment,
    input  wire logic [phra_pkg::ADDR_BITS-1:0]       address,
    input  wire logic [phra_pkg::ADDR_BITS-1:0]       fresh_page,
    input  wire logic [phra_pkg::SPLIT_W-1:0]         min_split,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [2:0]                                status,
    output logic [phra_pkg::ADDR_BITS-1:0]            result_address,
    output logic                                      page_taken,
    output logic [phra_pkg::ADDR_BITS-1:0]            released_page,
    output logic                                      busy
);

    localparam int AW = phra_pkg::ADDR_BITS;
    localparam int IW = phra_pkg::IDX_W;
    localparam int CW = phra_pkg::CNT_W;
    localparam int LW = phra_pkg::LEN_W;
    localparam logic [AW:0] AMAX = {1'b0, {AW{1'b1}}};
    localparam logic [AW:0] PGB  = (AW+1)'(phra_pkg::PAGE_BYTES);

    phra_pkg::state_t state_reg, state_next;
    phra_pkg::nu_goal_t goal_reg, goal_next;

    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] nu_reg, nu_next;
    logic          nu_ok_reg, nu_ok_next;
    logic [LW-1:0] size_reg, size_next;
    logic [12:0]   amask_reg, amask_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] fresh_reg, fresh_next;
    logic [AW-1:0] pg_reg, pg_next;
    logic [AW-1:0] bpage_reg, bpage_next;
    logic [LW-1:0] boff_reg, boff_next;
    phra_pkg::rec_t cur_reg, cur_next;

    logic [2:0]    st_reg, st_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic          pt_reg, pt_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic          ov_reg, ov_next;

    logic          we;
    logic [IW-1:0] waddr;
    phra_pkg::rec_t wdata, rdata;
    logic [IW-1:0] raddr;

    phra_ram #(.WIDTH(phra_pkg::REC_W), .DEPTH(phra_pkg::RECORDS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic        last_idx;
    logic [15:0] al_eff;
    logic        bad_req;
    logic [12:0] split_eff;
    logic [LW-1:0] tail;
    logic [AW:0] sum_s;
    logic [AW:0] bsum;
    logic [AW:0] at_b;
    logic [AW:0] at_f;
    logic        fit_b, fit_f;
    logic [AW:0] dist_b, dist_f;

    assign last_idx  = (idx_reg[IW-1:0] == IW'(phra_pkg::RECORDS - 1));
    assign al_eff    = (alignment == 16'd0) ? 16'd8 : alignment;
    assign bad_req   = (size == '0) || (size > 16'(phra_pkg::PAGE_BYTES))
                    || ((al_eff & (al_eff - 16'd1)) != 16'd0) || (al_eff > 16'd4096);
    assign split_eff = (min_split == '0) ? 13'd1 : min_split;
    assign tail      = rdata.len - size_reg;
    assign sum_s     = {1'b0, rdata.start} + (AW+1)'(size_reg);

    // bump candidate in the current page
    assign bsum   = {1'b0, bpage_reg} + (AW+1)'(boff_reg);
    assign at_b   = (bsum + (AW+1)'(amask_reg)) & ~(AW+1)'(amask_reg);
    assign dist_b = at_b - {1'b0, bpage_reg};
    assign fit_b  = (bpage_reg != '0) && (bsum + (AW+1)'(amask_reg) <= AMAX)
                 && (dist_b <= PGB) && ((AW+1)'(size_reg) <= PGB - dist_b);
    assign at_f   = ({1'b0, fresh_reg} + (AW+1)'(amask_reg)) & ~(AW+1)'(amask_reg);
    assign dist_f = at_f - {1'b0, fresh_reg};
    assign fit_f  = ({1'b0, fresh_reg} + (AW+1)'(amask_reg) <= AMAX)
                 && (dist_f <= PGB) && ((AW+1)'(size_reg) <= PGB - dist_f);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phra_pkg::S_CLEAR;
            idx_reg   <= '0;
            bpage_reg <= '0;
            boff_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bpage_reg <= bpage_next;
            boff_reg  <= boff_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        goal_reg  <= goal_next;
        nu_reg    <= nu_next;
        nu_ok_reg <= nu_ok_next;
        size_reg  <= size_next;
        amask_reg <= amask_next;
        addr_reg  <= addr_next;
        fresh_reg <= fresh_next;
        pg_reg    <= pg_next;
        cur_reg   <= cur_next;
        st_reg    <= st_next;
        ra_reg    <= ra_next;
        pt_reg    <= pt_next;
        rp_reg    <= rp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        goal_next  = goal_reg;
        idx_next   = idx_reg;
        nu_next    = nu_reg;
        nu_ok_next = nu_ok_reg;
        size_next  = size_reg;
        amask_next = amask_reg;
        addr_next  = addr_reg;
        fresh_next = fresh_reg;
        pg_next    = pg_reg;
        bpage_next = bpage_reg;
        boff_next  = boff_reg;
        cur_next   = cur_reg;
        st_next    = st_reg;
        ra_next    = ra_reg;
        pt_next    = pt_reg;
        rp_next    = rp_reg;
        ov_next    = ov_reg;
        we         = 1'b0;
        waddr      = idx_reg[IW-1:0];
        wdata      = '0;
        raddr      = idx_reg[IW-1:0];
        in_stall   = 1'b1;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            phra_pkg::S_CLEAR:
            begin
                we    = 1'b1;
                wdata = '0;
                idx_next = idx_reg + CW'(1);
                if (last_idx)
                begin
                    state_next = phra_pkg::S_IDLE;
                end
            end
            phra_pkg::S_IDLE:
            begin
                in_stall = ov_reg;
                if (in_valid && !ov_reg)
                begin
                    size_next  = size[LW-1:0];
                    amask_next = 13'(al_eff - 16'd1);
                    addr_next  = address;
                    fresh_next = fresh_page;
                    st_next    = phra_pkg::ST_NOT_FOUND;
                    ra_next    = '0;
                    pt_next    = 1'b0;
                    rp_next    = '0;
                    idx_next   = '0;
                    if (cmd)
                    begin
                        if (address == '0)
                        begin
                            state_next = phra_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = phra_pkg::S_FREE_RD;
                        end
                    end
                    else if (bad_req)
                    begin
                        st_next    = phra_pkg::ST_BAD;
                        state_next = phra_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = phra_pkg::S_FIT_RD;
                    end
                end
            end
            phra_pkg::S_FIT_RD:
            begin
                state_next = phra_pkg::S_FIT_CHK;
            end
            phra_pkg::S_FIT_CHK:
            begin
                if (!rdata.live && rdata.start != '0
                    && (rdata.start[12:0] & amask_reg) == '0
                    && sum_s <= AMAX && size_reg <= rdata.len)
                begin
                    cur_next = rdata;
                    we       = 1'b1;
                    wdata    = rdata;
                    wdata.len  = size_reg;
                    wdata.live = 1'b1;
                    st_next  = phra_pkg::ST_REUSED;
                    ra_next  = rdata.start;
                    if (tail >= LW'(split_eff))
                    begin
                        cur_next.start = sum_s[AW-1:0];
                        cur_next.len   = tail;
                        goal_next  = phra_pkg::NU_SPLIT;
                        idx_next   = '0;
                        nu_ok_next = 1'b0;
                        state_next = phra_pkg::S_NU_RD;
                    end
                    else
                    begin
                        state_next = phra_pkg::S_DONE;
                    end
                end
                else if (last_idx)
                begin
                    goal_next  = phra_pkg::NU_BUMP;
                    idx_next   = '0;
                    nu_ok_next = 1'b0;
                    state_next = phra_pkg::S_NU_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = phra_pkg::S_FIT_RD;
                end
            end
            phra_pkg::S_NU_RD:
            begin
                state_next = phra_pkg::S_NU_CHK;
            end
            phra_pkg::S_NU_CHK:
            begin
                if (!rdata.live && rdata.start == '0)
                begin
                    nu_next    = idx_reg[IW-1:0];
                    nu_ok_next = 1'b1;
                    state_next = (goal_reg == phra_pkg::NU_SPLIT)
                               ? phra_pkg::S_SPLIT_WR : phra_pkg::S_BUMP;
                end
                else if (last_idx)
                begin
                    state_next = (goal_reg == phra_pkg::NU_SPLIT)
                               ? phra_pkg::S_SPLIT_WR : phra_pkg::S_BUMP;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = phra_pkg::S_NU_RD;
                end
            end
            phra_pkg::S_SPLIT_WR:
            begin
                if (nu_ok_reg)
                begin
                    we         = 1'b1;
                    waddr      = nu_reg;
                    wdata      = cur_reg;
                    wdata.live = 1'b0;
                end
                state_next = phra_pkg::S_DONE;
            end
            phra_pkg::S_BUMP:
            begin
                state_next = phra_pkg::S_DONE;
                waddr      = nu_reg;
                if (!nu_ok_reg)
                begin
                    st_next = phra_pkg::ST_NO_RECORD;
                end
                else if (fit_b)
                begin
                    we         = 1'b1;
                    wdata.page = bpage_reg;
                    wdata.start = at_b[AW-1:0];
                    wdata.len  = size_reg;
                    wdata.live = 1'b1;
                    boff_next  = LW'(dist_b) + size_reg;
                    st_next    = phra_pkg::ST_BUMPED;
                    ra_next    = at_b[AW-1:0];
                end
                else if (fresh_reg == '0)
                begin
                    st_next = phra_pkg::ST_NO_PAGE;
                end
                else if (fit_f)
                begin
                    we          = 1'b1;
                    wdata.page  = fresh_reg;
                    wdata.start = at_f[AW-1:0];
                    wdata.len   = size_reg;
                    wdata.live  = 1'b1;
                    bpage_next  = fresh_reg;
                    boff_next   = LW'(dist_f) + size_reg;
                    st_next     = phra_pkg::ST_BUMPED;
                    ra_next     = at_f[AW-1:0];
                    pt_next     = 1'b1;
                end
                else
                begin
                    bpage_next = '0;
                    boff_next  = '0;
                    st_next    = phra_pkg::ST_NO_PAGE;
                    pt_next    = 1'b1;
                    rp_next    = fresh_reg;
                end
            end
            phra_pkg::S_FREE_RD:
            begin
                state_next = phra_pkg::S_FREE_CHK;
            end
            phra_pkg::S_FREE_CHK:
            begin
                if (rdata.live && rdata.start == addr_reg)
                begin
                    we         = 1'b1;
                    wdata      = rdata;
                    wdata.live = 1'b0;
                    pg_next    = rdata.page;
                    idx_next   = '0;
                    state_next = phra_pkg::S_LIVE_RD;
                end
                else if (last_idx)
                begin
                    state_next = phra_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = phra_pkg::S_FREE_RD;
                end
            end
            phra_pkg::S_LIVE_RD:
            begin
                state_next = phra_pkg::S_LIVE_CHK;
            end
            phra_pkg::S_LIVE_CHK:
            begin
                if (rdata.live && rdata.page == pg_reg)
                begin
                    st_next    = phra_pkg::ST_FREED;
                    state_next = phra_pkg::S_DONE;
                end
                else if (last_idx)
                begin
                    if (bpage_reg == pg_reg)
                    begin
                        bpage_next = '0;
                        boff_next  = '0;
                    end
                    st_next    = phra_pkg::ST_RELEASED;
                    rp_next    = pg_reg;
                    idx_next   = '0;
                    state_next = phra_pkg::S_DROP_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = phra_pkg::S_LIVE_RD;
                end
            end
            phra_pkg::S_DROP_RD:
            begin
                state_next = phra_pkg::S_DROP_CHK;
            end
            phra_pkg::S_DROP_CHK:
            begin
                if (rdata.page == pg_reg)
                begin
                    we    = 1'b1;
                    wdata = '0;
                end
                if (last_idx)
                begin
                    state_next = phra_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = phra_pkg::S_DROP_RD;
                end
            end
            phra_pkg::S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    state_next = phra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = phra_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign result_address = ra_reg;
    assign page_taken     = pt_reg;
    assign released_page  = rp_reg;
    assign busy           = (state_reg != phra_pkg::S_IDLE);

endmodule
`default_nettype wire

// File: design/page_heap_record_allocator.sv
// Page heap record allocator: serves allocate and free transfers against a 256-entry
// record table held in one single-port-read RAM, scanned record by record (read state,
// then check state) by a small sequencer. The shortest items are a bad request or a
// free of 0, the longest a free that releases a page (find, live check and drop scans).
// After reset a clearing pass over all 256 records runs before the first transfer is
// taken. The user must write min_split only while idle; the block does not enforce it.
`default_nettype none
`include "page_heap_record_allocator_assert.svh"
module page_heap_record_allocator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                cmd,
    input  wire logic [15:0]                         size,
    input  wire logic [15:0]                         alignment,
    input  wire logic [phra_pkg::ADDR_BITS-1:0]      address,
    input  wire logic [phra_pkg::ADDR_BITS-1:0]      fresh_page,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [2:0]                               status,
    output logic [phra_pkg::ADDR_BITS-1:0]           result_address,
    output logic                                     page_taken,
    output logic [phra_pkg::ADDR_BITS-1:0]           released_page,
    input  wire logic                                cfg_we,
    input  wire logic [phra_pkg::SPLIT_W-1:0]        cfg_wdata
);

    logic [phra_pkg::SPLIT_W-1:0] min_split_reg;
    logic                         busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_split_reg <= phra_pkg::SPLIT_W'(16);
        end
        else if (cfg_we)
        begin
            min_split_reg <= cfg_wdata;
        end
    end

    phra_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .size           (size),
        .alignment      (alignment),
        .address        (address),
        .fresh_page     (fresh_page),
        .min_split      (min_split_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_address (result_address),
        .page_taken     (page_taken),
        .released_page  (released_page),
        .busy           (busy)
    );

    `PHRA_ASSERT_IMP(a_no_take_busy, busy, in_stall, "input taken while busy")
    `PHRA_ASSERT_NEXT(a_one_result, in_valid && !in_stall, !out_valid,
        "stale result alongside new transfer")
    `PHRA_ASSERT_IMP(a_fail_zero, out_valid && status != phra_pkg::ST_REUSED
        && status != phra_pkg::ST_BUMPED, result_address == '0, "failure with address")

endmodule
`default_nettype wire

// File: tb/sv/page_heap_record_allocator_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module page_heap_record_allocator_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic                           cmd,
    input  wire logic [15:0]                    size,
    input  wire logic [15:0]                    alignment,
    input  wire logic [phra_pkg::ADDR_BITS-1:0] address,
    input  wire logic [phra_pkg::ADDR_BITS-1:0] fresh_page,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [2:0]                     status,
    input  wire logic [phra_pkg::ADDR_BITS-1:0] result_address,
    input  wire logic                           page_taken,
    input  wire logic [phra_pkg::ADDR_BITS-1:0] released_page,
    input  wire logic                           cfg_we,
    input  wire logic [phra_pkg::SPLIT_W-1:0]   cfg_wdata,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int AB = phra_pkg::ADDR_BITS;
    localparam int NREC = phra_pkg::RECORDS;

    typedef struct {
        logic [2:0]    st;
        logic [AB-1:0] addr;
        logic          taken;
        logic [AB-1:0] rel;
    } outcome_t;

    localparam logic [63:0] AMAX = (64'd1 << AB) - 1;

    outcome_t            outcome_q[$];
    logic [63:0]         m_page[NREC];
    logic [63:0]         m_start[NREC];
    logic [31:0]         m_len[NREC];
    logic                m_live[NREC];
    logic [63:0]         m_bump_page;
    logic [31:0]         m_bump_off;
    logic [12:0]         m_split;

    function automatic int first_unused();
        for (int i = 0; i < NREC; i++)
            if (!m_live[i] && m_start[i] == 0) return i;
        return -1;
    endfunction

    function automatic outcome_t mk(logic [2:0] st, logic [63:0] a, logic t, logic [63:0] r);
        outcome_t o;
        o.st = st;
        o.addr = a[AB-1:0];
        o.taken = t;
        o.rel = r[AB-1:0];
        return o;
    endfunction

    function automatic outcome_t free_block(logic [63:0] a);
        logic [63:0] pg;
        if (a == 0) return mk(phra_pkg::ST_NOT_FOUND, 0, 0, 0);
        for (int i = 0; i < NREC; i++)
        begin
            if (!m_live[i] || m_start[i] != a) continue;
            pg = m_page[i];
            m_live[i] = 0;
            for (int j = 0; j < NREC; j++)
                if (m_live[j] && m_page[j] == pg) return mk(phra_pkg::ST_FREED, 0, 0, 0);
            if (m_bump_page == pg)
            begin
                m_bump_page = 0;
                m_bump_off = 0;
            end
            for (int j = 0; j < NREC; j++)
                if (m_page[j] == pg)
                begin
                    m_page[j] = 0;
                    m_start[j] = 0;
                    m_len[j] = 0;
                    m_live[j] = 0;
                end
            return mk(phra_pkg::ST_RELEASED, 0, 0, pg);
        end
        return mk(phra_pkg::ST_NOT_FOUND, 0, 0, 0);
    endfunction

    function automatic bit align_up(logic [63:0] v, logic [63:0] al, output logic [63:0] r);
        logic [63:0] m;
        m = al - 1;
        r = 0;
        if (v > AMAX - m) return 0;
        r = (v + m) & ~m;
        return 1;
    endfunction

    function automatic outcome_t allocate_block(logic [63:0] sz, logic [63:0] al,
                                                logic [63:0] fresh);
        int rec;
        int t;
        logic [63:0] base;
        logic [63:0] at;
        logic [63:0] s;
        logic [31:0] tail;
        logic [31:0] split;
        bit fits;
        bit took;
        took = 0;
        split = (m_split == 0) ? 32'd1 : 32'(m_split);
        if (al == 0) al = 8;
        if (sz == 0 || sz > phra_pkg::PAGE_BYTES || (al & (al - 1)) != 0 || al > 4096)
            return mk(phra_pkg::ST_BAD, 0, 0, 0);
        for (int i = 0; i < NREC; i++)
        begin
            s = m_start[i];
            if (m_live[i] || s == 0) continue;
            if ((s & (al - 1)) != 0) continue;
            if (s > AMAX - sz || sz > m_len[i]) continue;
            tail = m_len[i] - sz[31:0];
            if (tail >= split)
            begin
                t = first_unused();
                if (t >= 0)
                begin
                    m_page[t] = m_page[i];
                    m_start[t] = s + sz;
                    m_len[t] = tail;
                    m_live[t] = 0;
                end
            end
            m_len[i] = sz[31:0];
            m_live[i] = 1;
            return mk(phra_pkg::ST_REUSED, s, 0, 0);
        end
        rec = first_unused();
        if (rec < 0) return mk(phra_pkg::ST_NO_RECORD, 0, 0, 0);
        base = m_bump_page;
        fits = 0;
        if (base != 0 && base <= AMAX - m_bump_off && align_up(base + m_bump_off, al, at))
            fits = (at - base) <= phra_pkg::PAGE_BYTES
                && sz <= phra_pkg::PAGE_BYTES - (at - base);
        if (!fits)
        begin
            if (fresh == 0) return mk(phra_pkg::ST_NO_PAGE, 0, 0, 0);
            took = 1;
            base = fresh;
            m_bump_page = fresh;
            m_bump_off = 0;
            if (align_up(base, al, at))
                fits = (at - base) <= phra_pkg::PAGE_BYTES
                    && sz <= phra_pkg::PAGE_BYTES - (at - base);
            if (!fits)
            begin
                m_bump_page = 0;
                m_bump_off = 0;
                return mk(phra_pkg::ST_NO_PAGE, 0, 1, fresh);
            end
        end
        m_page[rec] = base;
        m_start[rec] = at;
        m_len[rec] = sz[31:0];
        m_live[rec] = 1;
        m_bump_off = 32'(at + sz - base);
        return mk(phra_pkg::ST_BUMPED, at, took, 0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        outcome_t e;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int i = 0; i < NREC; i++)
            begin
                m_page[i] = 0;
                m_start[i] = 0;
                m_len[i] = 0;
                m_live[i] = 0;
            end
            m_bump_page = 0;
            m_bump_off = 0;
            m_split = 16;
            outcome_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                m_split = cfg_wdata;
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("unexpected result transfer, status %0d", status);
                    errs++;
                end
                else
                begin
                    e = outcome_q.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status expected %0d actual %0d", e.st, status);
                        errs++;
                    end
                    if (result_address !== e.addr)
                    begin
                        $error("result_address expected %h actual %h", e.addr, result_address);
                        errs++;
                    end
                    if (page_taken !== e.taken)
                    begin
                        $error("page_taken expected %0d actual %0d", e.taken, page_taken);
                        errs++;
                    end
                    if (released_page !== e.rel)
                    begin
                        $error("released_page expected %h actual %h", e.rel, released_page);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (cmd)
                    o = free_block(64'(address));
                else
                    o = allocate_block(64'(size), 64'(alignment), 64'(fresh_page));
                outcome_q.push_back(o);
            end
            fail_count <= fail_count + errs;
            pending <= outcome_q.size();
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_page_heap_record_allocator.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_page_heap_record_allocator;

    localparam int AB = phra_pkg::ADDR_BITS;
    localparam int SW = phra_pkg::SPLIT_W;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [15:0]          size;
    logic [15:0]          alignment;
    logic [AB-1:0]        address;
    logic [AB-1:0]        fresh_page;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           status;
    logic [AB-1:0]        result_address;
    logic                 page_taken;
    logic [AB-1:0]        released_page;
    logic                 cfg_we;
    logic [SW-1:0]        cfg_wdata;
    int                   fail_count;
    int                   pending;
    int                   quiet_cycles;
    logic [AB-1:0]        live_addrs[$];
    logic [AB-1:0]        next_page;

    localparam int QUIET_LIMIT = 40000;

    page_heap_record_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .size(size), .alignment(alignment),
        .address(address), .fresh_page(fresh_page),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_address(result_address),
        .page_taken(page_taken), .released_page(released_page),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    page_heap_record_allocator_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .size(size), .alignment(alignment),
        .address(address), .fresh_page(fresh_page),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_address(result_address),
        .page_taken(page_taken), .released_page(released_page),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // watchdog and random stall on the result side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            hold = gap_len();
            if (hold > 0)
            begin
                out_stall <= 1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    task automatic send(logic c, logic [15:0] sz, logic [15:0] al,
                        logic [AB-1:0] a, logic [AB-1:0] fp);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        size <= sz;
        alignment <= al;
        address <= a;
        fresh_page <= fp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0 || out_valid) @(posedge clk);
        repeat (1600) @(posedge clk);
    endtask

    task automatic set_split(logic [SW-1:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [AB-1:0] take_page();
        if ($urandom_range(0, 9) == 0) return 0;
        next_page = next_page + 48'h1000;
        if ($urandom_range(0, 19) == 0) return next_page | 48'(1 << $urandom_range(0, 11));
        return next_page;
    endfunction

    task automatic random_item(int mode);
        logic [15:0] sz;
        logic [15:0] al;
        int k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            send(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                 {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
        else if (r < 45 && live_addrs.size() > 0)
        begin
            k = $urandom_range(0, live_addrs.size() - 1);
            send(1, 16'($urandom), 16'($urandom), live_addrs[k], 0);
            live_addrs.delete(k);
        end
        else
        begin
            sz = (mode == 0) ? 16'($urandom_range(1, 64)) : 16'($urandom_range(1, 4096));
            al = (r % 7 == 0) ? 16'd0 : 16'(1 << $urandom_range(0, 12));
            send(0, sz, al, 0, take_page());
            // address is learnt from the output side below
        end
    endtask

    always @(posedge clk)
        if (out_valid && !out_stall
            && (status == phra_pkg::ST_REUSED || status == phra_pkg::ST_BUMPED))
            live_addrs.push_back(result_address);

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        cmd = 0;
        size = 0;
        alignment = 0;
        address = 0;
        fresh_page = 0;
        out_stall = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        quiet_cycles = 0;
        next_page = 48'h0001_0000_0000;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(0, 0, 8, 0, 48'h1000);
        send(0, 4097, 8, 0, 48'h1000);
        send(0, 8, 3, 0, 48'h1000);
        send(0, 8, 8192, 0, 48'h1000);
        send(0, 8, 0, 0, 0);
        send(0, 16'hFFFF, 16'hFFFF, 0, 0);
        send(0, 4096, 4096, 0, 48'hFFFF_FFFF_F000);
        send(0, 100, 1, 0, 48'h2000);
        send(0, 200, 64, 0, 0);
        send(0, 4000, 8, 0, 0);
        send(0, 4096, 4096, 0, 48'h3001);
        send(0, 32, 16, 0, 48'h4000);
        send(1, 0, 0, 0, 0);
        send(1, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send(1, 0, 0, 48'h2040, 0);
        send(0, 20, 4, 0, 0);
        send(1, 0, 0, 48'h2000, 0);
        send(1, 0, 0, 48'h4000, 0);
        send(0, 16, 8, 0, 48'h5000);

        set_split(0);
        for (int i = 0; i < 200; i++) random_item(0);
        set_split(13'h1FFF);
        for (int i = 0; i < 150; i++) random_item(1);
        set_split(1);
        for (int i = 0; i < 200; i++) random_item(0);
        set_split(4096);
        for (int i = 0; i < 200; i++) random_item($urandom_range(0, 1));

        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
+incdir+design
design/phra_pkg.sv
design/phra_ram.sv
design/phra_ctrl.sv
design/page_heap_record_allocator.sv
tb/sv/page_heap_record_allocator_checker.sv
tb/sv/tb_page_heap_record_allocator.sv
